@@ rtl/tmp_pkg.sv @@
// Shared types, constants and helper functions for the trapezoidal move profile unit.
package tmp_pkg;

    localparam int FRACTION_BITS = 16;
    localparam int TIME_BITS     = 16;
    localparam int POS_W         = 32;
    localparam int DUR_W         = 16;
    localparam int SP_W          = 48;
    localparam int WIDE          = 64;
    localparam int ACC_W         = WIDE + 1;
    localparam int CLAMP_SHIFT   = 62;
    localparam int MB_W          = (2 * TIME_BITS > DUR_W) ? 2 * TIME_BITS : DUR_W;
    localparam int CMP_W         = ((TIME_BITS > DUR_W) ? TIME_BITS : DUR_W) + 2;
    localparam int DVD_W         = POS_W + 1 + FRACTION_BITS;
    localparam int DVS_W         = DUR_W + 1;

    localparam logic signed [WIDE-1:0] SP_MAX =
        {{(WIDE - SP_W + 1){1'b0}}, {(SP_W - 1){1'b1}}};
    localparam logic signed [WIDE-1:0] SP_MIN =
        {{(WIDE - SP_W + 1){1'b1}}, {(SP_W - 1){1'b0}}};
    localparam logic [ACC_W-1:0] CLAMP_LIM =
        {{(ACC_W - CLAMP_SHIFT - 1){1'b0}}, 1'b1, {CLAMP_SHIFT{1'b0}}};

    typedef enum logic [1:0] {
        SEG_ACCEL  = 2'd0,
        SEG_CRUISE = 2'd1,
        SEG_DECEL  = 2'd2,
        SEG_HOLD   = 2'd3
    } seg_t;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_CAPTURE,
        OP_MOVE_SETUP,
        OP_DIV_PEAK,
        OP_PEAK_WR,
        OP_DIV_ACC,
        OP_ACC_WR,
        OP_MUL_RAMP,
        OP_RAMP_WR,
        OP_MUL_CRUISE,
        OP_CRUISE_WR,
        OP_TICK_ADV,
        OP_SQUARE,
        OP_MUL_ACC_TT,
        OP_MUL_PEAK_CR,
        OP_MUL_ACC_U,
        OP_MUL_INNER,
        OP_SET_WR,
        OP_OUT_LOAD
    } op_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_DECODE,
        ST_M_SETUP,
        ST_M_DIV_PEAK,
        ST_M_PEAK_WR,
        ST_M_DIV_ACC,
        ST_M_ACC_WR,
        ST_M_MUL_RAMP,
        ST_M_RAMP_WR,
        ST_M_MUL_CRUISE,
        ST_M_CRUISE_WR,
        ST_T_ADV,
        ST_T_BRANCH,
        ST_T_SQUARE,
        ST_T_MUL1,
        ST_T_MUL2,
        ST_T_SET,
        ST_FINISH
    } state_t;

    typedef struct packed {
        op_t  op;
        seg_t seg;
    } cmd_t;

    typedef struct packed {
        logic mul_done;
        logic div_done;
        logic following;
        logic kind_move;
        seg_t seg_class;
    } status_t;

    function automatic logic signed [SP_W-1:0] sat_sp(input logic signed [WIDE-1:0] v);
        logic signed [SP_W-1:0] r;
        if (v > SP_MAX) begin
            r = SP_MAX[SP_W-1:0];
        end else if (v < SP_MIN) begin
            r = SP_MIN[SP_W-1:0];
        end else begin
            r = v[SP_W-1:0];
        end
        return r;
    endfunction

    function automatic logic signed [WIDE-1:0] ext_sp(input logic signed [SP_W-1:0] x);
        return {{(WIDE - SP_W){x[SP_W-1]}}, x};
    endfunction

    function automatic logic signed [WIDE-1:0] fix_pos(input logic signed [POS_W-1:0] p);
        return {{(WIDE - POS_W - FRACTION_BITS){p[POS_W-1]}}, p, {FRACTION_BITS{1'b0}}};
    endfunction

endpackage

@@ rtl/trapezoidal_move_profile_unit.sv @@
// A move request runs two divisions and two multiplies, each followed by a write state, before
// its result is registered; a tick advances time and branches, then goes straight to the
// result when not following, writes the goal when holding at it, and otherwise runs one shared
// shift-add multiply on accelerate (after squaring elapsed time) and cruise, two on decelerate.
// Throughput: one request in flight; the next is taken the cycle after its result is registered,
// while that result may still wait on m_ready; an untaken result stalls the following one.
// Reset (aresetn low, synchronous) clears the sequencer, the output valid and all profile state.
module trapezoidal_move_profile_unit (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic                             s_kind,
    input  logic signed [tmp_pkg::POS_W-1:0] s_encoder_count,
    input  logic signed [tmp_pkg::POS_W-1:0] s_goal_position,
    input  logic        [tmp_pkg::DUR_W-1:0] s_move_time,
    input  logic        [tmp_pkg::DUR_W-1:0] s_ramp_time,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic signed [tmp_pkg::SP_W-1:0]  m_setpoint,
    output logic                             m_following,
    output logic        [1:0]                m_segment
);
    import tmp_pkg::*;

    cmd_t    cmd;
    status_t status;

    tmp_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    tmp_datapath u_datapath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_kind          (s_kind),
        .s_encoder_count (s_encoder_count),
        .s_goal_position (s_goal_position),
        .s_move_time     (s_move_time),
        .s_ramp_time     (s_ramp_time),
        .cmd             (cmd),
        .status          (status),
        .m_setpoint      (m_setpoint),
        .m_following     (m_following),
        .m_segment       (m_segment)
    );

endmodule

@@ rtl/tmp_div.sv @@
// Restoring signed-by-unsigned divider, one quotient bit per cycle, truncates toward zero.
module tmp_div (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             start,
    input  logic signed [tmp_pkg::DVD_W-1:0] dividend,
    input  logic        [tmp_pkg::DVS_W-1:0] divisor,
    output logic                             done,
    output logic signed [tmp_pkg::DVD_W:0]   quotient
);
    import tmp_pkg::*;

    localparam int CNT_W = $clog2(DVD_W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DVD_W - 1);

    logic             busy_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [DVD_W-1:0] q_reg;
    logic [DVS_W-1:0] rem_reg;
    logic [DVS_W-1:0] dvs_reg;
    logic             neg_reg;

    logic [DVD_W-1:0] dvd_bits;
    logic [DVD_W-1:0] dvd_mag;
    logic [DVS_W:0]   trial;
    logic [DVS_W:0]   trial_sub;
    logic             fits;
    logic [DVD_W:0]   q_ext;
    logic             launch;

    assign launch    = start && !busy_reg;
    assign dvd_bits  = dividend;
    assign dvd_mag   = dvd_bits[DVD_W-1] ? (~dvd_bits + DVD_W'(1)) : dvd_bits;
    assign trial     = {rem_reg, q_reg[DVD_W-1]};
    assign fits      = trial >= {1'b0, dvs_reg};
    assign trial_sub = trial - {1'b0, dvs_reg};
    assign done      = busy_reg && (cnt_reg == CNT_LAST);
    assign q_ext     = {1'b0, q_reg};
    assign quotient  = neg_reg ? (~q_ext + (DVD_W + 1)'(1)) : q_ext;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (launch) begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg + CNT_W'(1);
            if (done) begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (launch) begin
            q_reg   <= dvd_mag;
            rem_reg <= '0;
            dvs_reg <= divisor;
            neg_reg <= dvd_bits[DVD_W-1];
        end else if (busy_reg) begin
            q_reg   <= {q_reg[DVD_W-2:0], fits};
            rem_reg <= fits ? trial_sub[DVS_W-1:0] : trial[DVS_W-1:0];
        end
    end

endmodule

@@ rtl/tmp_mul.sv @@
// Shift-add multiplier, one multiplier bit per cycle, product magnitude clamped to 2^62.
module tmp_mul (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            start,
    input  logic signed [tmp_pkg::WIDE-1:0] a_in,
    input  logic        [tmp_pkg::MB_W-1:0] b_in,
    output logic                            done,
    output logic signed [tmp_pkg::WIDE-1:0] product,
    output logic signed [tmp_pkg::WIDE-1:0] half
);
    import tmp_pkg::*;

    localparam int CNT_W = $clog2(MB_W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(MB_W - 1);

    logic             busy_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [WIDE-1:0]  a_reg;
    logic [MB_W-1:0]  b_reg;
    logic [ACC_W-1:0] acc_reg;
    logic             neg_reg;

    logic             launch;
    logic [WIDE-1:0]  a_bits;
    logic [WIDE-1:0]  a_mag;
    logic [ACC_W-1:0] acc_dbl;
    logic [ACC_W-1:0] addend;
    logic [ACC_W-1:0] acc_sum;
    logic [ACC_W-1:0] acc_step;
    logic [WIDE-1:0]  mag;
    logic [WIDE-1:0]  mag_half;

    assign launch   = start && !busy_reg;
    assign a_bits   = a_in;
    assign a_mag    = a_bits[WIDE-1] ? (~a_bits + WIDE'(1)) : a_bits;
    assign acc_dbl  = {acc_reg[ACC_W-2:0], 1'b0};
    assign addend   = b_reg[MB_W-1] ? {1'b0, a_reg} : '0;
    assign acc_sum  = acc_dbl + addend;
    // once over the limit the running value stays pinned there
    assign acc_step = (acc_sum > CLAMP_LIM) ? CLAMP_LIM : acc_sum;
    assign done     = busy_reg && (cnt_reg == CNT_LAST);
    assign mag      = acc_reg[WIDE-1:0];
    assign mag_half = {1'b0, mag[WIDE-1:1]};
    assign product  = neg_reg ? (~mag + WIDE'(1)) : mag;
    assign half     = neg_reg ? (~mag_half + WIDE'(1)) : mag_half;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (launch) begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg + CNT_W'(1);
            if (done) begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (launch) begin
            a_reg   <= a_mag;
            b_reg   <= b_in;
            acc_reg <= '0;
            neg_reg <= a_bits[WIDE-1];
        end else if (busy_reg) begin
            acc_reg <= acc_step;
            b_reg   <= {b_reg[MB_W-2:0], 1'b0};
        end
    end

endmodule

@@ rtl/tmp_datapath.sv @@
// Datapath: profile state, shared divider and multiplier, setpoint math and result register.
module tmp_datapath (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_kind,
    input  logic signed [tmp_pkg::POS_W-1:0] s_encoder_count,
    input  logic signed [tmp_pkg::POS_W-1:0] s_goal_position,
    input  logic        [tmp_pkg::DUR_W-1:0] s_move_time,
    input  logic        [tmp_pkg::DUR_W-1:0] s_ramp_time,
    input  tmp_pkg::cmd_t                    cmd,
    output tmp_pkg::status_t                 status,
    output logic signed [tmp_pkg::SP_W-1:0]  m_setpoint,
    output logic                             m_following,
    output logic        [1:0]                m_segment
);
    import tmp_pkg::*;

    // captured request and squared elapsed time
    logic                    kind_reg;
    logic signed [POS_W-1:0] enc_reg;
    logic signed [POS_W-1:0] goal_reg;
    logic [DUR_W-1:0]        mt_reg;
    logic [DUR_W-1:0]        rt_reg;
    logic [MB_W-1:0]         tt_reg;

    // profile state
    logic                    following_reg, following_next;
    logic signed [POS_W-1:0] start_reg, start_next;
    logic signed [POS_W-1:0] target_reg, target_next;
    logic [DUR_W-1:0]        ramp_reg, ramp_next;
    logic [DUR_W-1:0]        cruise_reg, cruise_next;
    logic [TIME_BITS-1:0]    elapsed_reg, elapsed_next;
    logic signed [SP_W-1:0]  peak_reg, peak_next;
    logic signed [SP_W-1:0]  accel_reg, accel_next;
    logic signed [SP_W-1:0]  ramp_end_reg, ramp_end_next;
    logic signed [SP_W-1:0]  cruise_end_reg, cruise_end_next;
    logic signed [SP_W-1:0]  held_reg, held_next;

    // result register
    logic signed [SP_W-1:0]  out_sp_reg;
    logic                    out_fol_reg;
    seg_t                    out_seg_reg;

    logic [DUR_W:0]          twice_r;
    logic [DUR_W:0]          mt_less;
    logic [DUR_W-1:0]        cruise_calc;
    logic [DVS_W-1:0]        span;
    logic [CMP_W-1:0]        t_cmp, r_cmp, c_cmp, t_minus_r, u_cmp;
    logic [MB_W-1:0]         b_cr, b_u;
    seg_t                    seg_class;
    logic signed [POS_W:0]   delta_pos;
    logic signed [WIDE-1:0]  base;

    logic                    div_start, div_done;
    logic signed [DVD_W-1:0] div_dvd;
    logic [DVS_W-1:0]        div_dvs;
    logic signed [DVD_W:0]   div_quot;
    logic signed [WIDE-1:0]  quot_wide;

    logic                    mul_start, mul_done;
    logic signed [WIDE-1:0]  mul_a;
    logic [MB_W-1:0]         mul_b;
    logic signed [WIDE-1:0]  mul_prod, mul_half;
    logic signed [WIDE-1:0]  inner;
    logic signed [WIDE-1:0]  set_val;

    assign twice_r     = {rt_reg, 1'b0};
    assign mt_less     = {1'b0, mt_reg} - twice_r;
    assign cruise_calc = (twice_r < {1'b0, mt_reg}) ? mt_less[DUR_W-1:0] : '0;
    assign span        = {1'b0, ramp_reg} + {1'b0, cruise_reg};

    assign t_cmp     = CMP_W'(elapsed_reg);
    assign r_cmp     = CMP_W'(ramp_reg);
    assign c_cmp     = CMP_W'(cruise_reg);
    assign t_minus_r = t_cmp - r_cmp;
    assign u_cmp     = t_minus_r - c_cmp;
    assign b_cr      = MB_W'(t_minus_r[TIME_BITS-1:0]);
    assign b_u       = MB_W'(u_cmp[TIME_BITS-1:0]);

    always_comb begin
        if (t_cmp <= r_cmp) begin
            seg_class = SEG_ACCEL;
        end else if (t_cmp <= r_cmp + c_cmp) begin
            seg_class = SEG_CRUISE;
        end else if (t_cmp <= r_cmp + r_cmp + c_cmp) begin
            seg_class = SEG_DECEL;
        end else begin
            seg_class = SEG_HOLD;
        end
    end

    assign delta_pos = {target_reg[POS_W-1], target_reg} - {start_reg[POS_W-1], start_reg};
    assign base      = fix_pos(start_reg);

    assign div_start = (cmd.op == OP_DIV_PEAK) || (cmd.op == OP_DIV_ACC);
    assign div_dvd   = (cmd.op == OP_DIV_PEAK) ? {delta_pos, {FRACTION_BITS{1'b0}}}
                     : {{(DVD_W - SP_W){peak_reg[SP_W-1]}}, peak_reg};
    assign div_dvs   = (cmd.op == OP_DIV_PEAK) ? span : {1'b0, ramp_reg};
    assign quot_wide = {{(WIDE - DVD_W - 1){div_quot[DVD_W]}}, div_quot};

    tmp_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dvd),
        .divisor  (div_dvs),
        .done     (div_done),
        .quotient (div_quot)
    );

    assign inner = ext_sp(peak_reg) - mul_half;

    always_comb begin
        mul_start = 1'b1;
        mul_a     = ext_sp(peak_reg);
        mul_b     = MB_W'(ramp_reg);
        case (cmd.op)
            OP_MUL_RAMP: begin
                mul_a = ext_sp(peak_reg);
                mul_b = MB_W'(ramp_reg);
            end
            OP_MUL_CRUISE: begin
                mul_a = ext_sp(peak_reg);
                mul_b = MB_W'(cruise_reg);
            end
            OP_MUL_ACC_TT: begin
                mul_a = ext_sp(accel_reg);
                mul_b = tt_reg;
            end
            OP_MUL_PEAK_CR: begin
                mul_a = ext_sp(peak_reg);
                mul_b = b_cr;
            end
            OP_MUL_ACC_U: begin
                mul_a = ext_sp(accel_reg);
                mul_b = b_u;
            end
            OP_MUL_INNER: begin
                mul_a = inner;
                mul_b = b_u;
            end
            default: begin
                mul_start = 1'b0;
            end
        endcase
    end

    tmp_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .a_in    (mul_a),
        .b_in    (mul_b),
        .done    (mul_done),
        .product (mul_prod),
        .half    (mul_half)
    );

    always_comb begin
        case (cmd.seg)
            SEG_ACCEL:  set_val = base + mul_half;
            SEG_CRUISE: set_val = base + ext_sp(ramp_end_reg) + mul_prod;
            SEG_DECEL:  set_val = base + ext_sp(cruise_end_reg) + mul_prod;
            default:    set_val = fix_pos(target_reg);
        endcase
    end

    always_comb begin
        following_next  = following_reg;
        start_next      = start_reg;
        target_next     = target_reg;
        ramp_next       = ramp_reg;
        cruise_next     = cruise_reg;
        elapsed_next    = elapsed_reg;
        peak_next       = peak_reg;
        accel_next      = accel_reg;
        ramp_end_next   = ramp_end_reg;
        cruise_end_next = cruise_end_reg;
        held_next       = held_reg;
        unique case (cmd.op)
            OP_MOVE_SETUP: begin
                following_next = 1'b1;
                start_next     = enc_reg;
                target_next    = goal_reg;
                ramp_next      = rt_reg;
                cruise_next    = cruise_calc;
                elapsed_next   = '0;
            end
            OP_PEAK_WR: begin
                peak_next = (span == '0) ? '0 : sat_sp(quot_wide);
            end
            OP_ACC_WR: begin
                accel_next = (ramp_reg == '0) ? '0 : div_quot[SP_W-1:0];
            end
            OP_RAMP_WR: begin
                ramp_end_next = sat_sp(mul_half);
            end
            OP_CRUISE_WR: begin
                cruise_end_next = sat_sp(ext_sp(ramp_end_reg) + ext_sp(sat_sp(mul_prod)));
            end
            OP_TICK_ADV: begin
                if (elapsed_reg != '1) begin
                    elapsed_next = elapsed_reg + TIME_BITS'(1);
                end
                if (enc_reg == target_reg) begin
                    following_next = 1'b0;
                end
            end
            OP_SET_WR: begin
                held_next = sat_sp(set_val);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            following_reg  <= 1'b0;
            start_reg      <= '0;
            target_reg     <= '0;
            ramp_reg       <= '0;
            cruise_reg     <= '0;
            elapsed_reg    <= '0;
            peak_reg       <= '0;
            accel_reg      <= '0;
            ramp_end_reg   <= '0;
            cruise_end_reg <= '0;
            held_reg       <= '0;
        end else begin
            following_reg  <= following_next;
            start_reg      <= start_next;
            target_reg     <= target_next;
            ramp_reg       <= ramp_next;
            cruise_reg     <= cruise_next;
            elapsed_reg    <= elapsed_next;
            peak_reg       <= peak_next;
            accel_reg      <= accel_next;
            ramp_end_reg   <= ramp_end_next;
            cruise_end_reg <= cruise_end_next;
            held_reg       <= held_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.op == OP_CAPTURE) begin
            kind_reg <= s_kind;
            enc_reg  <= s_encoder_count;
            goal_reg <= s_goal_position;
            mt_reg   <= s_move_time;
            rt_reg   <= s_ramp_time;
        end
        if (cmd.op == OP_SQUARE) begin
            tt_reg <= MB_W'(elapsed_reg) * MB_W'(elapsed_reg);
        end
        if (cmd.op == OP_OUT_LOAD) begin
            out_sp_reg  <= held_reg;
            out_fol_reg <= following_reg;
            out_seg_reg <= cmd.seg;
        end
    end

    assign m_setpoint  = out_sp_reg;
    assign m_following = out_fol_reg;
    assign m_segment   = out_seg_reg;

    assign status.mul_done  = mul_done;
    assign status.div_done  = div_done;
    assign status.following = following_reg;
    assign status.kind_move = kind_reg;
    assign status.seg_class = seg_class;

endmodule

@@ rtl/tmp_ctrl.sv @@
// Controller: sequences move setup and tick evaluation, owns both handshakes.
module tmp_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    output logic             m_valid,
    input  logic             m_ready,
    input  tmp_pkg::status_t status,
    output tmp_pkg::cmd_t    cmd
);
    import tmp_pkg::*;

    state_t state_reg, state_next;
    seg_t   seg_reg, seg_next;
    logic   m_valid_reg, m_valid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            seg_reg     <= SEG_HOLD;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            seg_reg     <= seg_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_comb begin
        state_next   = state_reg;
        seg_next     = seg_reg;
        m_valid_next = m_valid_reg && !m_ready;
        s_ready      = 1'b0;
        cmd.op       = OP_NONE;
        cmd.seg      = seg_reg;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.op     = OP_CAPTURE;
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE: begin
                state_next = status.kind_move ? ST_M_SETUP : ST_T_ADV;
            end
            ST_M_SETUP: begin
                cmd.op     = OP_MOVE_SETUP;
                state_next = ST_M_DIV_PEAK;
            end
            ST_M_DIV_PEAK: begin
                cmd.op = OP_DIV_PEAK;
                if (status.div_done) begin
                    state_next = ST_M_PEAK_WR;
                end
            end
            ST_M_PEAK_WR: begin
                cmd.op     = OP_PEAK_WR;
                state_next = ST_M_DIV_ACC;
            end
            ST_M_DIV_ACC: begin
                cmd.op = OP_DIV_ACC;
                if (status.div_done) begin
                    state_next = ST_M_ACC_WR;
                end
            end
            ST_M_ACC_WR: begin
                cmd.op     = OP_ACC_WR;
                state_next = ST_M_MUL_RAMP;
            end
            ST_M_MUL_RAMP: begin
                cmd.op = OP_MUL_RAMP;
                if (status.mul_done) begin
                    state_next = ST_M_RAMP_WR;
                end
            end
            ST_M_RAMP_WR: begin
                cmd.op     = OP_RAMP_WR;
                state_next = ST_M_MUL_CRUISE;
            end
            ST_M_MUL_CRUISE: begin
                cmd.op = OP_MUL_CRUISE;
                if (status.mul_done) begin
                    state_next = ST_M_CRUISE_WR;
                end
            end
            ST_M_CRUISE_WR: begin
                cmd.op     = OP_CRUISE_WR;
                seg_next   = SEG_ACCEL;
                state_next = ST_FINISH;
            end
            ST_T_ADV: begin
                cmd.op     = OP_TICK_ADV;
                state_next = ST_T_BRANCH;
            end
            ST_T_BRANCH: begin
                if (!status.following) begin
                    seg_next   = SEG_HOLD;
                    state_next = ST_FINISH;
                end else begin
                    seg_next = status.seg_class;
                    case (status.seg_class) inside
                        SEG_ACCEL:             state_next = ST_T_SQUARE;
                        SEG_CRUISE, SEG_DECEL: state_next = ST_T_MUL1;
                        default:               state_next = ST_T_SET;
                    endcase
                end
            end
            ST_T_SQUARE: begin
                cmd.op     = OP_SQUARE;
                state_next = ST_T_MUL1;
            end
            ST_T_MUL1: begin
                case (seg_reg)
                    SEG_ACCEL:  cmd.op = OP_MUL_ACC_TT;
                    SEG_CRUISE: cmd.op = OP_MUL_PEAK_CR;
                    default:    cmd.op = OP_MUL_ACC_U;
                endcase
                if (status.mul_done) begin
                    state_next = (seg_reg == SEG_DECEL) ? ST_T_MUL2 : ST_T_SET;
                end
            end
            ST_T_MUL2: begin
                cmd.op = OP_MUL_INNER;
                if (status.mul_done) begin
                    state_next = ST_T_SET;
                end
            end
            ST_T_SET: begin
                cmd.op     = OP_SET_WR;
                state_next = ST_FINISH;
            end
            ST_FINISH: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.op       = OP_OUT_LOAD;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_valid = m_valid_reg;

endmodule
